// ===== rtl/hcbd_pkg.sv =====
// shared types and constants for the chunked body decoder
package hcbd_pkg;

  localparam logic [7:0]  CHAR_CR            = 8'd13;
  localparam logic [7:0]  CHAR_LF            = 8'd10;
  localparam logic [31:0] MAX_TRANSFER_RESET = 32'h0010_0000;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;
  localparam logic [1:0] KIND_LIMIT = 2'd3;

  typedef enum logic [6:0] {
    PH_SIZE_FIRST = 7'b000_0001,
    PH_SIZE_MORE  = 7'b000_0010,
    PH_SIZE_LF    = 7'b000_0100,
    PH_DATA       = 7'b000_1000,
    PH_TAIL_CR    = 7'b001_0000,
    PH_TAIL_LF    = 7'b010_0000,
    PH_HALT       = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] len;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      h.val = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      h.val = 4'(c - 8'd55);
    end else if (c >= 8'd97 && c <= 8'd102) begin
      h.val = 4'(c - 8'd87);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/hcbd_deframer.sv =====
// framing state machine: parses size lines, passes data, checks the limit
module hcbd_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           in_byte,
  input  logic [31:0]          max_transfer,
  output hcbd_pkg::push_t      res
);
  import hcbd_pkg::*;

  phase_t      phase_r,      phase_nxt;
  logic [30:0] chunk_left_r, chunk_left_nxt;
  logic        final_r,      final_nxt;
  logic [31:0] raw_count_r,  raw_count_nxt;
  logic [31:0] body_count_r, body_count_nxt;
  hex_t        hx;

  assign hx = hex_decode(in_byte);

  always_comb begin
    phase_nxt      = phase_r;
    chunk_left_nxt = chunk_left_r;
    final_nxt      = final_r;
    raw_count_nxt  = raw_count_r;
    body_count_nxt = body_count_r;
    res            = '0;
    if (acc && phase_r != PH_HALT) begin
      if (raw_count_r >= max_transfer) begin
        phase_nxt     = PH_HALT;
        res.push      = 1'b1;
        res.res.kind  = KIND_LIMIT;
      end else begin
        raw_count_nxt = raw_count_r + 32'd1;
        case (phase_r)
          PH_SIZE_FIRST, PH_SIZE_MORE: begin
            if (hx.ok) begin
              if (chunk_left_r[30:27] != 4'd0) begin
                phase_nxt    = PH_HALT;
                res.push     = 1'b1;
                res.res.kind = KIND_FRAME;
              end else begin
                chunk_left_nxt = {chunk_left_r[26:0], hx.val};
                phase_nxt      = PH_SIZE_MORE;
              end
            end else if (phase_r == PH_SIZE_FIRST) begin
              phase_nxt    = PH_HALT;
              res.push     = 1'b1;
              res.res.kind = KIND_FRAME;
            end else if (in_byte == CHAR_CR) begin
              phase_nxt = PH_SIZE_LF;
            end else if (in_byte == CHAR_LF) begin
              if (chunk_left_r == 31'd0) begin
                final_nxt = 1'b1;
                phase_nxt = PH_TAIL_CR;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else begin
              phase_nxt    = PH_HALT;
              res.push     = 1'b1;
              res.res.kind = KIND_FRAME;
            end
          end
          PH_SIZE_LF: begin
            if (in_byte != CHAR_LF) begin
              phase_nxt    = PH_HALT;
              res.push     = 1'b1;
              res.res.kind = KIND_FRAME;
            end else if (chunk_left_r == 31'd0) begin
              final_nxt = 1'b1;
              phase_nxt = PH_TAIL_CR;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            chunk_left_nxt = chunk_left_r - 31'd1;
            body_count_nxt = body_count_r + 32'd1;
            if (chunk_left_r == 31'd1) begin
              phase_nxt = PH_TAIL_CR;
            end
            res.push     = 1'b1;
            res.res.kind = KIND_DATA;
            res.res.data = in_byte;
          end
          PH_TAIL_CR, PH_TAIL_LF: begin
            if (in_byte == CHAR_LF) begin
              // end of a chunk line; the zero-size chunk closes the body
              if (final_r) begin
                phase_nxt    = PH_HALT;
                res.push     = 1'b1;
                res.res.kind = KIND_END;
                res.res.len  = body_count_r;
              end else begin
                phase_nxt      = PH_SIZE_FIRST;
                chunk_left_nxt = 31'd0;
              end
            end else if (in_byte == CHAR_CR && phase_r == PH_TAIL_CR) begin
              phase_nxt = PH_TAIL_LF;
            end else begin
              phase_nxt    = PH_HALT;
              res.push     = 1'b1;
              res.res.kind = KIND_FRAME;
            end
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE_FIRST;
      chunk_left_r <= '0;
      final_r      <= 1'b0;
      raw_count_r  <= '0;
      body_count_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      chunk_left_r <= chunk_left_nxt;
      final_r      <= final_nxt;
      raw_count_r  <= raw_count_nxt;
      body_count_r <= body_count_nxt;
    end
  end

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Chunked transfer decoder for an HTTP response body, one raw byte per item.
// An item is taken every cycle; its result, if any, is registered and shown
// on the out channel the cycle after if out_r is free or popped; else a second
// result register holds it meanwhile, so the input only stalls with two results
// pending. Data bytes come out as kind data, the zero-size chunk ends the body
// with its decoded length, and framing faults or a raw count beyond
// max_transfer give an error result; after any end or error result the block
// takes and drops every byte until reset. cfg_ready is always high.
module http_chunked_body_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] out_body_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import hcbd_pkg::*;

  logic [31:0] max_transfer_r;
  logic        acc;
  push_t       step;
  logic        pop;
  logic        out_valid_r, skid_valid_r;
  result_t     out_r, skid_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_transfer_r <= MAX_TRANSFER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_transfer_r <= cfg_data;
    end
  end

  hcbd_deframer u_deframer (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .in_byte      (in_byte),
    .max_transfer (max_transfer_r),
    .res          (step)
  );

  // two-deep result holding: main register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (step.push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (step.push) begin
      if (!out_valid_r || pop) begin
        out_r <= step.res;
      end else begin
        skid_r <= step.res;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_byte        = out_r.data;
  assign out_body_length = out_r.len;

endmodule

// ===== rtl/hcbd_checker.sv =====
// port-level checks for the chunked body decoder, bound to the top level
module hcbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [31:0] out_body_length,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_data
);
  import hcbd_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_byte, cfg_valid, cfg_ready, cfg_data};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_body_length))
    else $error("result changed while stalled");

  // input only stalls while results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // an end or error result is the last one
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != KIND_DATA |=> !out_valid)
    else $error("result after end or error");

  a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("byte set on a non-data result");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
